>>> rtl/looping_timeline_cue_trigger_core_assert.svh
// Assertion macros used by the timeline cue trigger RTL.
`ifndef LOOPING_TIMELINE_CUE_TRIGGER_CORE_ASSERT_SVH
`define LOOPING_TIMELINE_CUE_TRIGGER_CORE_ASSERT_SVH

// Same-cycle implication, reset masks the check.
`define LTCT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ltct assertion failed");

// Next-cycle implication, reset masks the check.
`define LTCT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ltct assertion failed");

`endif

>>> rtl/ltct_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package ltct_pkg;

    localparam int MAX_CUES   = 16;
    localparam int NUM_SOUNDS = 64;

    localparam int TIME_W  = 16;
    localparam int DELTA_W = 16;
    localparam int SND_W   = 6;
    localparam int POS_W   = 17;
    localparam int LEN_W   = 16;

    localparam int CNT_W  = $clog2(MAX_CUES + 1);
    localparam int IDX_W  = (MAX_CUES > 1) ? $clog2(MAX_CUES) : 1;
    localparam int FLAG_W = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int USER_W     = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_EN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SND = 2'd2;

    typedef enum logic [1:0] {
        FUNC_ADVANCE = 2'd0,
        FUNC_APPEND  = 2'd1,
        FUNC_JUMP    = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        KIND_SOUND = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FULL  = 2'd2
    } t_kind;

    // Where the sound id of an emitted word comes from
    typedef enum logic [1:0] {
        SRC_START = 2'd0,
        SRC_CUE   = 2'd1,
        SRC_DONE  = 2'd2
    } t_src;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_DECODE = 3'd1,
        ST_START  = 3'd2,
        ST_STEP   = 3'd3,
        ST_SCAN   = 3'd4,
        ST_DONE   = 3'd5
    } t_state;

    typedef struct packed {
        logic  load;
        logic  append;
        logic  jump;
        logic  step;
        logic  scan_clr;
        logic  scan_next;
        logic  emit;
        t_src  src;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       full;
        logic       adv_ok;
        logic       pos_zero;
        logic       scan_end;
        logic       hit;
        logic       out_free;
    } t_stat;

endpackage

>>> rtl/ltct_ctrl.sv
// Sequencing state machine for decode, start sound, step, cue scan and done word.
module ltct_ctrl
    import ltct_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    t_kind  r_kind,  n_kind;

    // Hold state and the kind of the closing word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= KIND_DONE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_cmd      = '0;
        o_cmd.src  = SRC_DONE;
        o_cmd.kind = KIND_DONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_kind  = KIND_DONE;
                n_state = ST_DONE;
                case (i_stat.func)
                    FUNC_APPEND: begin
                        if (i_stat.full) begin
                            n_kind = KIND_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                        end
                    end
                    FUNC_JUMP: begin
                        o_cmd.jump = 1'b1;
                    end
                    FUNC_ADVANCE: begin
                        if (i_stat.adv_ok) begin
                            n_state = i_stat.pos_zero ? ST_START : ST_STEP;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_START: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_START;
                    o_cmd.kind = KIND_SOUND;
                    n_state    = ST_STEP;
                end
            end
            ST_STEP: begin
                o_cmd.step     = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state        = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = ST_DONE;
                end else if (i_stat.hit) begin
                    // wait for room before emitting a cue sound
                    if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.src       = SRC_CUE;
                        o_cmd.kind      = KIND_SOUND;
                        o_cmd.scan_next = 1'b1;
                    end
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_DONE;
                    o_cmd.kind = r_kind;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/ltct_dpath.sv
// Timeline datapath: config, position, cue table, played flags, output register.
module ltct_dpath
    import ltct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [1:0]            i_in_func,
    input  logic [DELTA_W-1:0]    i_in_delta,
    input  logic [TIME_W-1:0]     i_in_cue_time,
    input  logic [SND_W-1:0]      i_in_cue_sound,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [1:0]            o_out_kind,
    output logic [SND_W-1:0]      o_out_sound,
    output logic [POS_W-1:0]      o_out_pos,
    output logic                  o_out_last
);

    logic [LEN_W-1:0]   r_seq_len;
    logic               r_loop_en;
    logic [SND_W-1:0]   r_start_snd;

    logic [1:0]         r_func;
    logic [DELTA_W-1:0] r_delta;
    logic [TIME_W-1:0]  r_ctime;
    logic [SND_W-1:0]   r_csound;

    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_old;
    logic               r_wrapped;

    logic [TIME_W-1:0]  r_cue_time  [MAX_CUES];
    logic [SND_W-1:0]   r_cue_sound [MAX_CUES];
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_scan;
    logic [NUM_SOUNDS-1:0] r_played;

    logic               r_out_valid;
    logic [1:0]         r_out_kind;
    logic [SND_W-1:0]   r_out_sound;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_last;

    logic [POS_W:0]     sum;
    logic [POS_W-1:0]   sat;
    logic [POS_W-1:0]   len_ext;
    logic               wrap;
    logic [POS_W-1:0]   n_pos;
    logic [TIME_W-1:0]  ent_time;
    logic [SND_W-1:0]   ent_snd;
    logic [POS_W-1:0]   ent_t;
    logic [FLAG_W-1:0]  flag_idx;
    logic               in_win;
    logic               out_free;
    logic [SND_W-1:0]   emit_snd;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len   <= '0;
            r_loop_en   <= 1'b0;
            r_start_snd <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_SEQ_LEN:   r_seq_len   <= i_cfg_wdata[LEN_W-1:0];
                CFG_LOOP_EN:   r_loop_en   <= i_cfg_wdata[0];
                CFG_START_SND: r_start_snd <= i_cfg_wdata[SND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Capture the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_in_func;
            r_delta  <= i_in_delta;
            r_ctime  <= i_in_cue_time;
            r_csound <= i_in_cue_sound;
        end
    end

    // Saturating advance with a single wrap
    assign len_ext = POS_W'(r_seq_len);
    assign sum     = {1'b0, r_pos} + (POS_W + 1)'(r_delta);
    assign sat     = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
    assign wrap    = r_loop_en && (sat > len_ext);
    assign n_pos   = wrap ? (sat - len_ext) : sat;

    // Update position and the scan window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.jump) begin
            r_pos <= len_ext;
        end else if (i_cmd.step) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_old     <= r_pos;
            r_wrapped <= n_pos < r_pos;
        end
    end

    // Append cues
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_cue_time[r_cnt[IDX_W-1:0]]  <= r_ctime;
            r_cue_sound[r_cnt[IDX_W-1:0]] <= r_csound;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.append) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Advance the scan pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_next) begin
            r_scan <= r_scan + CNT_W'(1);
        end
    end

    // Evaluate the cue under the pointer
    assign ent_time = r_cue_time[r_scan[IDX_W-1:0]];
    assign ent_snd  = r_cue_sound[r_scan[IDX_W-1:0]];
    assign ent_t    = POS_W'(ent_time);
    assign flag_idx = FLAG_W'(ent_snd % NUM_SOUNDS);
    assign in_win   = r_wrapped ? ((ent_t >= r_old) || (ent_t <= r_pos))
                                : ((ent_t >= r_old) && (ent_t <= r_pos));

    // Clear played flags on a wrap, set them on each cue sound
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_played <= '0;
        end else if (i_cmd.step && wrap) begin
            r_played <= '0;
        end else if (i_cmd.emit && (i_cmd.src == SRC_CUE)) begin
            r_played[flag_idx] <= 1'b1;
        end
    end

    // Output register
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (i_cmd.src)
            SRC_START: emit_snd = r_start_snd;
            SRC_CUE:   emit_snd = ent_snd;
            default:   emit_snd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind  <= i_cmd.kind;
            r_out_sound <= emit_snd;
            r_out_pos   <= r_pos;
            r_out_last  <= i_cmd.src == SRC_DONE;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_sound = r_out_sound;
    assign o_out_pos   = r_out_pos;
    assign o_out_last  = r_out_last;

    // Status to the controller
    always_comb begin
        o_stat          = '0;
        o_stat.func     = r_func;
        o_stat.full     = r_cnt == CNT_W'(MAX_CUES);
        o_stat.adv_ok   = (r_func == FUNC_ADVANCE) && (r_seq_len != '0) &&
                          !(!r_loop_en && (r_pos > len_ext));
        o_stat.pos_zero = r_pos == '0;
        o_stat.scan_end = r_scan >= r_cnt;
        o_stat.hit      = in_win && !r_played[flag_idx];
        o_stat.out_free = out_free;
    end

endmodule

>>> rtl/looping_timeline_cue_trigger_core.sv
// Looping timeline cue trigger: top level joining controller and datapath.
// Input stream: tuser carries func (0 advance, 1 append cue, 2 jump to end);
// tdata carries delta, cue_time and cue_sound. One word is taken at a time.
// Output stream: every input word yields one or more words; tuser gives the
// kind (sound, step done, table full), tdata the sound id and the position,
// and tlast marks the final word belonging to an input word.
// Configuration: write length, loop enable or start sound while idle.
// Sequence: an append or jump is decoded, then its done word is emitted.
// An advance that may proceed runs decode, an optional start sound, the
// position step, one scan step per stored cue plus one to end the scan, then
// the done word; each sound and the done word wait for room in the output
// register. Once the done word is loaded into the output register, the
// controller returns to idle and takes the next word.
// Reset clears position, cue count, played flags and configuration; cue
// table contents stay undefined until appended.
// A stalled receiver holds the output register; the scan waits on each
// pending sound, and a new input word is taken while the last word waits.
`include "looping_timeline_cue_trigger_core_assert.svh"

module looping_timeline_cue_trigger_core
    import ltct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // delta[15:0], cue_time[31:16], cue_sound[37:32]
    input  logic [USER_W-1:0]     i_s_axis_tuser,  // func[1:0]
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // sound_id[5:0], position[22:6]
    output logic [USER_W-1:0]     o_m_axis_tuser,  // kind[1:0]
    output logic                  o_m_axis_tlast
);

    t_cmd             cmd;
    t_stat            stat;
    logic [1:0]       out_kind;
    logic [SND_W-1:0] out_sound;
    logic [POS_W-1:0] out_pos;

    ltct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ltct_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_func      (i_s_axis_tuser[1:0]),
        .i_in_delta     (i_s_axis_tdata[DELTA_W-1:0]),
        .i_in_cue_time  (i_s_axis_tdata[DELTA_W+TIME_W-1:DELTA_W]),
        .i_in_cue_sound (i_s_axis_tdata[DELTA_W+TIME_W+SND_W-1:DELTA_W+TIME_W]),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_out_kind     (out_kind),
        .o_out_sound    (out_sound),
        .o_out_pos      (out_pos),
        .o_out_last     (o_m_axis_tlast)
    );

    // Pack the result word
    assign o_m_axis_tuser = out_kind;
    assign o_m_axis_tdata = {{(OUT_DATA_W - POS_W - SND_W){1'b0}}, out_pos, out_sound};

    // One input word in flight at a time
    `LTCT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // Sound words never close an input word, done and full words always do
    `LTCT_ASSERT_IMP(a_last_matches_kind, i_clk, i_rst_n,
        o_m_axis_tvalid, o_m_axis_tlast == (o_m_axis_tuser != KIND_SOUND))

    // A pending sound word means the input word is still being worked on
    `LTCT_ASSERT_IMP(a_sound_while_busy, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_SOUND), !o_s_axis_tready)

endmodule
